/* rtl/core/skh_pkg.sv */
// ----------------------------------------------------------------------------
// skh_pkg: shared types and constants of the key hash unit
// Widths, register indexes, hash modes, state codes, the symbol code table
// and the request and response groups of the remainder unit.
// ----------------------------------------------------------------------------
package skh_pkg;

  localparam int ACC_W    = 32;   // accumulator width, wraps modulo 2^32
  localparam int SIZE_W   = 15;   // table size, share count, remainders
  localparam int BUCKET_W = 14;   // bucket field at the output
  localparam int INDEX_W  = 14;   // share index register
  localparam int BYTE_W   = 8;
  localparam int CODE_W   = 5;    // symbol codes 1 to 17
  localparam int CNT_W    = $clog2(ACC_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  // Largest number of buckets; a larger table size is clamped to it.
  localparam logic [SIZE_W-1:0] MAX_BUCKETS = SIZE_W'(16384);

  localparam logic [SIZE_W-1:0]  TABLE_SIZE_RST  = SIZE_W'(10000);
  localparam logic [SIZE_W-1:0]  SHARE_COUNT_RST = SIZE_W'(1);
  localparam logic [INDEX_W-1:0] SHARE_INDEX_RST = '0;

  localparam logic [CFG_IDX_W-1:0] REG_HASH_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_COUNT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHARE_INDEX = 2'd3;

  typedef enum logic [1:0] {
    MODE_LENGTH  = 2'd0,
    MODE_SUM     = 2'd1,
    MODE_ELEMENT = 2'd2,
    MODE_CARBON  = 2'd3
  } hash_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REDUCE,
    ST_BUCKET,
    ST_SHARE,
    ST_PUT
  } skh_state_t;

  typedef struct packed {
    logic              start;
    logic [ACC_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } div_rsp_t;

  // Element code of one SMILES character; every other byte gets 17.
  function automatic logic [CODE_W-1:0] symbol_code(input logic [BYTE_W-1:0] b);
    logic [CODE_W-1:0] code;
    case (b)
      8'h43:   code = 5'd1;   // C
      8'h63:   code = 5'd2;   // c
      8'h4E:   code = 5'd3;   // N
      8'h6E:   code = 5'd4;   // n
      8'h4F:   code = 5'd5;   // O
      8'h6F:   code = 5'd6;   // o
      8'h50:   code = 5'd7;   // P
      8'h53:   code = 5'd8;   // S
      8'h28:   code = 5'd9;   // (
      8'h29:   code = 5'd10;  // )
      8'h5B:   code = 5'd11;  // [
      8'h5D:   code = 5'd12;  // ]
      8'h31:   code = 5'd13;  // 1
      8'h32:   code = 5'd14;  // 2
      8'h3D:   code = 5'd15;  // =
      8'h23:   code = 5'd16;  // #
      default: code = 5'd17;
    endcase
    return code;
  endfunction

  localparam logic [BYTE_W-1:0] CHAR_UPPER_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_LOWER_C = 8'h63;

endpackage

/* rtl/core/skh_if.sv */
// ----------------------------------------------------------------------------
// skh_if: item channels of the key hash unit
// Valid/ready channels for key characters and for finished buckets.
// ----------------------------------------------------------------------------
interface skh_in_if;
  logic                       valid;
  logic                       ready;
  logic [skh_pkg::BYTE_W-1:0] key_byte;
  logic                       key_last;

  modport source (output valid, output key_byte, output key_last, input ready);
  modport sink   (input valid, input key_byte, input key_last, output ready);
endinterface

interface skh_out_if;
  logic                         valid;
  logic                         ready;
  logic [skh_pkg::BUCKET_W-1:0] bucket;
  logic                         in_share;

  modport source (output valid, output bucket, output in_share, input ready);
  modport sink   (input valid, input bucket, input in_share, output ready);
endinterface

/* rtl/core/skh_div.sv */
// ----------------------------------------------------------------------------
// skh_div: iterative remainder unit
// Restoring division, one quotient bit per cycle, remainder only. A dividend
// below four times the divisor takes two steps, any other takes 32.
// ----------------------------------------------------------------------------
module skh_div (
  input  logic              clk,
  input  logic              rst,
  input  skh_pkg::div_req_t req,
  output skh_pkg::div_rsp_t rsp
);

  logic                               busy;
  logic                               done;
  logic [skh_pkg::CNT_W-1:0]          cnt;
  logic [skh_pkg::SIZE_W-1:0]         rem;
  logic [skh_pkg::ACC_W-1:0]          shreg;
  logic [skh_pkg::SIZE_W-1:0]         divisor;
  logic [skh_pkg::SIZE_W:0]           trial;
  logic                               fits;
  logic                               fast;

  // The short path starts with the top bits already below the divisor.
  assign fast  = req.dividend < {{(skh_pkg::ACC_W-skh_pkg::SIZE_W-2){1'b0}},
                                 req.divisor, 2'b00};
  assign trial = {rem, shreg[skh_pkg::ACC_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= fast ? skh_pkg::CNT_W'(1) : skh_pkg::CNT_W'(skh_pkg::ACC_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      divisor <= req.divisor;
      if (fast) begin
        rem   <= req.dividend[skh_pkg::SIZE_W+1:2];
        shreg <= {req.dividend[1:0], {(skh_pkg::ACC_W-2){1'b0}}};
      end else begin
        rem   <= '0;
        shreg <= req.dividend;
      end
    end else if (busy) begin
      rem   <= fits ? skh_pkg::SIZE_W'(trial - {1'b0, divisor})
                    : trial[skh_pkg::SIZE_W-1:0];
      shreg <= {shreg[skh_pkg::ACC_W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = rem;

endmodule

/* rtl/core/smiles_key_hash_unit.sv */
// ----------------------------------------------------------------------------
// smiles_key_hash_unit: bucket hash of a character key
// Folds one key character per item into a 32-bit accumulator and, on the
// last character, returns the bucket number and its share membership.
// ----------------------------------------------------------------------------
// Each character is accepted, then checked, before the next one is taken; in
// carbon-binary mode a reduction and a second check follow when the accumulator
// has grown past the table size. After the last character come the check, any
// reduction, the bucket and share remainders (short when the dividend is below 4x
// the divisor, on the one shared unit) and one load, plus any result wait.
// Reset is synchronous and active high: state, accumulator, flags and config reset.
// ----------------------------------------------------------------------------
module smiles_key_hash_unit (
  input  logic                           clk,
  input  logic                           rst,
  skh_in_if.sink                         in_ch,
  skh_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [skh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skh_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  skh_pkg::hash_mode_t            hash_mode;
  logic [skh_pkg::SIZE_W-1:0]     table_size;
  logic [skh_pkg::SIZE_W-1:0]     share_count;
  logic [skh_pkg::INDEX_W-1:0]    share_index;

  // Sequencer and datapath state.
  skh_pkg::skh_state_t            state;
  skh_pkg::skh_state_t            state_next;
  logic [skh_pkg::ACC_W-1:0]      acc;
  logic                           last;
  logic [skh_pkg::BUCKET_W-1:0]   bucket;
  logic                           match;
  logic                           out_valid;
  logic [skh_pkg::BUCKET_W-1:0]   out_bucket;
  logic                           out_in_share;

  logic [skh_pkg::ACC_W-1:0]      acc_upd;
  logic [skh_pkg::SIZE_W-1:0]     size_eff;
  logic [skh_pkg::SIZE_W-1:0]     shares_eff;
  logic                           is_carbon;
  logic                           need_reduce;
  logic                           accept;
  logic                           load_out;
  logic                           in_ready;
  skh_pkg::div_req_t              div_req;
  skh_pkg::div_rsp_t              div_rsp;

  // A table size of zero acts as one bucket and an oversized one is clamped;
  // a share count of zero acts as one share.
  assign size_eff   = (table_size == '0) ? skh_pkg::SIZE_W'(1) :
                      (table_size > skh_pkg::MAX_BUCKETS) ? skh_pkg::MAX_BUCKETS :
                      table_size;
  assign shares_eff = (share_count == '0) ? skh_pkg::SIZE_W'(1) : share_count;

  assign is_carbon = (in_ch.key_byte == skh_pkg::CHAR_UPPER_C) ||
                     (in_ch.key_byte == skh_pkg::CHAR_LOWER_C);

  // The per-character update of the accumulator, done in the accept cycle.
  // Carbon-binary mode triples acc as acc + 2*acc, adds one per carbon, 32-bit wrap.
  always_comb begin
    case (hash_mode)
      skh_pkg::MODE_LENGTH:  acc_upd = acc + skh_pkg::ACC_W'(1);
      skh_pkg::MODE_SUM:     acc_upd = acc + skh_pkg::ACC_W'(in_ch.key_byte);
      skh_pkg::MODE_ELEMENT: acc_upd = acc +
                                       skh_pkg::ACC_W'(skh_pkg::symbol_code(in_ch.key_byte));
      skh_pkg::MODE_CARBON:  acc_upd = acc + {acc[skh_pkg::ACC_W-2:0], 1'b0}
                                       + skh_pkg::ACC_W'(is_carbon);
      default:               acc_upd = acc;
    endcase
  end

  // In carbon-binary mode the accumulator is brought back below the table
  // size whenever it has grown past it.
  assign need_reduce = (hash_mode == skh_pkg::MODE_CARBON) &&
                       (acc > skh_pkg::ACC_W'(size_eff));

  assign accept   = in_ch.valid && in_ready;
  assign load_out = (state == skh_pkg::ST_PUT) && (!out_valid || out_ch.ready);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      skh_pkg::ST_IDLE: begin
        if (accept) state_next = skh_pkg::ST_CHECK;
      end
      skh_pkg::ST_CHECK: begin
        if (need_reduce)  state_next = skh_pkg::ST_REDUCE;
        else if (last)    state_next = skh_pkg::ST_BUCKET;
        else              state_next = skh_pkg::ST_IDLE;
      end
      skh_pkg::ST_REDUCE: begin
        // After the reduction the check runs again and finds no further reduction to do.
        if (div_rsp.done) state_next = skh_pkg::ST_CHECK;
      end
      skh_pkg::ST_BUCKET: begin
        if (div_rsp.done) state_next = skh_pkg::ST_SHARE;
      end
      skh_pkg::ST_SHARE: begin
        if (div_rsp.done) state_next = skh_pkg::ST_PUT;
      end
      skh_pkg::ST_PUT: begin
        if (load_out) state_next = skh_pkg::ST_IDLE;
      end
      default: state_next = skh_pkg::ST_IDLE;
    endcase
  end

  // Output logic: input ready and the request to the remainder unit. The
  // unit computes acc mod size for a reduction or the bucket, then
  // bucket mod shares for the share test.
  always_comb begin
    in_ready         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = acc;
    div_req.divisor  = size_eff;
    case (state)
      skh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      skh_pkg::ST_CHECK: begin
        div_req.start = need_reduce || last;
      end
      skh_pkg::ST_BUCKET: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = skh_pkg::ACC_W'(div_rsp.rem);
        div_req.divisor  = shares_eff;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = in_ready;

  skh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Configuration registers, to be written only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_mode   <= skh_pkg::MODE_CARBON;
      table_size  <= skh_pkg::TABLE_SIZE_RST;
      share_count <= skh_pkg::SHARE_COUNT_RST;
      share_index <= skh_pkg::SHARE_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        skh_pkg::REG_HASH_MODE:   hash_mode   <= skh_pkg::hash_mode_t'(cfg_data[1:0]);
        skh_pkg::REG_TABLE_SIZE:  table_size  <= cfg_data;
        skh_pkg::REG_SHARE_COUNT: share_count <= cfg_data;
        skh_pkg::REG_SHARE_INDEX: share_index <= cfg_data[skh_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state, accumulator and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skh_pkg::ST_IDLE;
      acc       <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        acc  <= acc_upd;
        last <= in_ch.key_last;
      end else if (state == skh_pkg::ST_REDUCE && div_rsp.done) begin
        acc <= skh_pkg::ACC_W'(div_rsp.rem);
      end else if (state == skh_pkg::ST_BUCKET && div_rsp.done) begin
        // The key is finished once its bucket is known.
        acc <= '0;
      end
      if (load_out)          out_valid <= 1'b1;
      else if (out_ch.ready) out_valid <= 1'b0;
    end
  end

  // Result payload. A share index beyond the share count never matches,
  // because the remainder is always below the effective count. The bucket is below
  // the effective table size, so it fits the output field.
  always_ff @(posedge clk) begin
    if (state == skh_pkg::ST_BUCKET && div_rsp.done) begin
      bucket <= div_rsp.rem[skh_pkg::BUCKET_W-1:0];
    end
    if (state == skh_pkg::ST_SHARE && div_rsp.done) begin
      match <= (div_rsp.rem == skh_pkg::SIZE_W'(share_index));
    end
    if (load_out) begin
      out_bucket   <= bucket;
      out_in_share <= match;
    end
  end

  assign out_ch.valid    = out_valid;
  assign out_ch.bucket   = out_bucket;
  assign out_ch.in_share = out_in_share;

endmodule

/* rtl/core/skh_checker.sv */
// ----------------------------------------------------------------------------
// skh_checker: port-level assertions of the key hash unit
// Follows the configuration writes and checks the items seen at the ports.
// ----------------------------------------------------------------------------
module skh_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [skh_pkg::BUCKET_W-1:0]   out_bucket,
  input logic                           out_in_share,
  input logic                           cfg_we,
  input logic [skh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [skh_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic [skh_pkg::SIZE_W-1:0]  table_size;
  logic [skh_pkg::SIZE_W-1:0]  share_count;
  logic [skh_pkg::INDEX_W-1:0] share_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size  <= skh_pkg::TABLE_SIZE_RST;
      share_count <= skh_pkg::SHARE_COUNT_RST;
      share_index <= skh_pkg::SHARE_INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        skh_pkg::REG_TABLE_SIZE:  table_size  <= cfg_data;
        skh_pkg::REG_SHARE_COUNT: share_count <= cfg_data;
        skh_pkg::REG_SHARE_INDEX: share_index <= cfg_data[skh_pkg::INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Input ready drops in the cycle after a character is accepted.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted right after the first");

  // The bucket lies below the table size; a table of one or zero gives 0.
  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (({1'b0, out_bucket} < table_size) || (table_size == '0)) &&
                  ((table_size > skh_pkg::SIZE_W'(1)) || (out_bucket == '0)))
    else $error("bucket not below the table size");

  // With a share count of one or zero and index zero every bucket is in the share.
  a_single_share: assert property (@(posedge clk) disable iff (rst)
    out_valid && (share_count <= skh_pkg::SIZE_W'(1)) && (share_index == '0)
    |-> out_in_share)
    else $error("bucket left out of the only share");

endmodule

bind smiles_key_hash_unit skh_checker u_skh_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_bucket   (out_ch.bucket),
  .out_in_share (out_ch.in_share),
  .cfg_we       (cfg_we),
  .cfg_index    (cfg_index),
  .cfg_data     (cfg_data)
);
